[design/gsc_pkg.sv]
// ----------------------------------------------------------------------------
// gsc_pkg
// Types, codes and constants shared by the gear shift controller modules.
// ----------------------------------------------------------------------------
package gsc_pkg;

  localparam int unsigned TOP_GEAR = 4;

  localparam int unsigned GEAR_W  = 3;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned PINS_W  = 2;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CADDR_W = 2;
  localparam int unsigned CDATA_W = 16;
  localparam int unsigned IDATA_W = 8;
  localparam int unsigned ODATA_W = 24;

  localparam logic [GEAR_W-1:0] GEAR_FIRST = GEAR_W'(1);
  localparam logic [GEAR_W-1:0] GEAR_TOP   = GEAR_W'(TOP_GEAR);
  localparam logic [TICK_W-1:0] TICK_MAX   = '1;

  localparam logic [TICK_W-1:0] DEBOUNCE_RST = TICK_W'(1000);
  localparam logic [TICK_W-1:0] SETTLE_RST   = TICK_W'(500);
  localparam logic [DUTY_W-1:0] OPEN_RST     = DUTY_W'(125);
  localparam logic [DUTY_W-1:0] CLOSED_RST   = DUTY_W'(255);

  // input commands
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DOWN = 2'd2;

  // configuration register indexes
  localparam logic [CADDR_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CADDR_W-1:0] REG_SETTLE   = 2'd1;
  localparam logic [CADDR_W-1:0] REG_OPEN     = 2'd2;
  localparam logic [CADDR_W-1:0] REG_CLOSED   = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_OPEN  = 3'b010,
    PH_CLOSE = 3'b100
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] settle_ticks;
    logic [DUTY_W-1:0] open_duty;
    logic [DUTY_W-1:0] closed_duty;
  } cfg_t;

  typedef struct packed {
    logic [GEAR_W-1:0] desired_gear;
    logic [GEAR_W-1:0] active_gear;
    logic              press_allowed;
    logic [TICK_W-1:0] ticks_since_press;
    phase_t            phase;
    logic [TICK_W-1:0] phase_timer;
    logic [PINS_W-1:0] pins;
    logic [DUTY_W-1:0] duty;
    logic              turbo;
    logic              relay;
  } ctl_state_t;

  function automatic logic [PINS_W-1:0] pins_for(input logic [GEAR_W-1:0] gear);
    logic [PINS_W-1:0] p;
    unique case (gear)
      3'd1:    p = 2'd1;
      3'd2:    p = 2'd0;
      3'd3:    p = 2'd2;
      3'd4:    p = 2'd3;
      default: p = 2'd1;
    endcase
    return p;
  endfunction

endpackage

[design/gsc_step.sv]
// ----------------------------------------------------------------------------
// gsc_step
// Next-state logic: debounced gear presses, shift sequencer, relay and turbo.
// ----------------------------------------------------------------------------
module gsc_step (
  input  gsc_pkg::ctl_state_t           cur,
  input  gsc_pkg::cfg_t                 cfg,
  input  logic [gsc_pkg::CMD_W-1:0]     cmd,
  input  logic                          ecu_on,
  input  logic                          turbo_on,
  output gsc_pkg::ctl_state_t           nxt
);
  import gsc_pkg::*;

  logic              press_ok;
  logic [TICK_W-1:0] timer_inc;
  logic              wait_done;
  logic [GEAR_W-1:0] act_up;
  logic [GEAR_W-1:0] des_up;

  assign press_ok  = (cur.ticks_since_press > cfg.debounce_ticks) && cur.press_allowed;
  assign timer_inc = (cur.phase_timer != TICK_MAX) ? cur.phase_timer + TICK_W'(1)
                                                   : cur.phase_timer;
  assign wait_done = timer_inc >= cfg.settle_ticks;
  assign act_up    = cur.active_gear + GEAR_W'(1);
  assign des_up    = cur.desired_gear + GEAR_W'(1);

  always_comb begin
    nxt = cur;
    unique case (cmd)
      CMD_UP, CMD_DOWN: begin
        if (press_ok) begin
          if (cmd == CMD_UP) begin
            if (cur.desired_gear < GEAR_TOP) nxt.desired_gear = des_up;
          end else begin
            if (cur.desired_gear > GEAR_FIRST) nxt.desired_gear = cur.desired_gear - GEAR_W'(1);
          end
          nxt.ticks_since_press = '0;
          nxt.press_allowed     = 1'b0;
        end
      end
      CMD_TICK: begin
        if (cur.ticks_since_press != TICK_MAX)
          nxt.ticks_since_press = cur.ticks_since_press + TICK_W'(1);

        unique case (cur.phase)
          PH_OPEN: begin
            nxt.phase_timer = timer_inc;
            if (wait_done) begin
              nxt.active_gear = cur.desired_gear;
              nxt.pins        = pins_for(cur.desired_gear);
              nxt.duty        = cfg.closed_duty;
              nxt.phase       = PH_CLOSE;
              nxt.phase_timer = '0;
            end
          end
          PH_CLOSE: begin
            nxt.phase_timer = timer_inc;
            if (wait_done) begin
              nxt.press_allowed = 1'b1;
              nxt.phase         = PH_IDLE;
              nxt.phase_timer   = '0;
            end
          end
          default: begin
            if (ecu_on && (cur.desired_gear != cur.active_gear)) begin
              nxt.press_allowed = 1'b0;
              // one gear step per shift
              if (cur.desired_gear > act_up)
                nxt.desired_gear = act_up;
              else if (des_up < cur.active_gear)
                nxt.desired_gear = cur.active_gear - GEAR_W'(1);
              nxt.duty        = cfg.open_duty;
              nxt.phase       = PH_OPEN;
              nxt.phase_timer = '0;
            end
          end
        endcase

        if (ecu_on) begin
          nxt.relay = 1'b0;
          nxt.turbo = turbo_on;
        end else begin
          nxt.relay         = 1'b1;
          nxt.press_allowed = 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

[design/sequential_gear_shift_controller_top.sv]
// ----------------------------------------------------------------------------
// sequential_gear_shift_controller_top
// Gear shift controller with stream input/output and a write-only config port.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Each accepted beat (tick, up or down press) lands
// in an input register; once the result register is empty or drains, the
// controller state and the result register are updated from it. A new beat
// is taken every cycle as long as the result register drains, and a waiting
// result does not stop an empty input register from filling. Clutch wait times
// and the press debounce window count tick beats, not clock cycles. Config
// writes take effect at the next clock edge.
module sequential_gear_shift_controller_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [gsc_pkg::IDATA_W-1:0]    in_tdata,  // [0] ecu_switch, [1] turbo_switch
  input  logic [gsc_pkg::CMD_W-1:0]      in_tuser,  // [1:0] cmd
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [1:0] gear_pins, [9:2] clutch_duty, [10] turbo_drive, [11] ecu_relay,
  // [14:12] engaged_gear, [17:15] wanted_gear, [18] shifting
  output logic [gsc_pkg::ODATA_W-1:0]    out_tdata,
  input  logic                           cfg_we,
  input  logic [gsc_pkg::CADDR_W-1:0]    cfg_addr,
  input  logic [gsc_pkg::CDATA_W-1:0]    cfg_wdata
);
  import gsc_pkg::*;

  cfg_t               cfg_r, cfg_nxt;
  ctl_state_t         st_r, st_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  logic [CMD_W-1:0]   s1_cmd_r;
  logic               s1_ecu_r;
  logic               s1_turbo_r;
  logic               out_valid_r, out_valid_nxt;
  logic [ODATA_W-1:0] out_data_r, out_data_nxt;
  logic               adv;
  logic               in_acc;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  gsc_step u_step (
    .cur      (st_r),
    .cfg      (cfg_r),
    .cmd      (s1_cmd_r),
    .ecu_on   (s1_ecu_r),
    .turbo_on (s1_turbo_r),
    .nxt      (st_nxt)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEBOUNCE: cfg_nxt.debounce_ticks = cfg_wdata;
        REG_SETTLE:   cfg_nxt.settle_ticks   = cfg_wdata;
        REG_OPEN:     cfg_nxt.open_duty      = cfg_wdata[DUTY_W-1:0];
        REG_CLOSED:   cfg_nxt.closed_duty    = cfg_wdata[DUTY_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)
      s1_valid_nxt = 1'b1;
    else if (adv)
      s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (adv)
      out_valid_nxt = 1'b1;
    else if (out_tready)
      out_valid_nxt = 1'b0;

    out_data_nxt = {5'b0, (st_nxt.phase != PH_IDLE), st_nxt.desired_gear,
                    st_nxt.active_gear, st_nxt.relay, st_nxt.turbo,
                    st_nxt.duty, st_nxt.pins};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{debounce_ticks: DEBOUNCE_RST, settle_ticks: SETTLE_RST,
                       open_duty: OPEN_RST, closed_duty: CLOSED_RST};
      st_r        <= '{desired_gear: GEAR_FIRST, active_gear: GEAR_FIRST,
                       press_allowed: 1'b1, ticks_since_press: TICK_MAX,
                       phase: PH_IDLE, phase_timer: '0,
                       pins: pins_for(GEAR_FIRST), duty: CLOSED_RST,
                       turbo: 1'b0, relay: 1'b0};
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv)
        st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r   <= in_tuser;
      s1_ecu_r   <= in_tdata[0];
      s1_turbo_r <= in_tdata[1];
    end
    if (adv)
      out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // pins always follow the engaged gear
  a_pins_match: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pins == pins_for(st_r.active_gear))
    else $error("gear pins do not match engaged gear");

  // presses are only re-allowed once a shift has finished
  a_allow_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.press_allowed |-> (st_r.phase == PH_IDLE))
    else $error("presses allowed during a shift");

  a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_IDLE) |-> (st_r.phase_timer == '0))
    else $error("phase timer running while idle");

  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.desired_gear >= GEAR_FIRST) && (st_r.desired_gear <= GEAR_TOP))
    else $error("wanted gear out of range");

  // a completed step always leaves a result behind
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("result lost after step");

endmodule
